>>> sv/bdq_pkg.sv
// Shared types, codes and constants for the bounded deque with remove-by-value.
package bdq_pkg;

  // Default sizing of the entry store.
  localparam int unsigned DepthDef     = 16;
  localparam int unsigned DataWidthDef = 32;

  // Fixed widths of the item fields.
  localparam int unsigned FuncW   = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  // Request codes.
  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH_BACK  = 3'd0,
    FUNC_PUSH_FRONT = 3'd1,
    FUNC_POP_BACK   = 3'd2,
    FUNC_POP_FRONT  = 3'd3,
    FUNC_REMOVE     = 3'd4
  } func_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP_WAIT,
    ST_SCAN,
    ST_SHIFT_RD,
    ST_SHIFT_WR
  } state_e;

  // Read address selection.
  typedef enum logic [2:0] {
    RD_BACK,
    RD_FRONT,
    RD_IDX,
    RD_NEXT,
    RD_NEXT2
  } rd_sel_e;

  // Write address and data selection.
  typedef enum logic [1:0] {
    WR_BACK,
    WR_FRONT,
    WR_SHIFT
  } wr_sel_e;

  // Source of the returned value.
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RDATA,
    RES_HELD
  } res_sel_e;

  // Input item.
  typedef struct packed {
    logic [FuncW-1:0]         func;
    logic signed [ValueW-1:0] item_value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic signed [ValueW-1:0] out_value;
    logic [CountW-1:0]        entry_count;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    logic     idx_inc;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     head_inc;
    logic     head_dec;
    logic     hold_rdata;
    logic     emit;
    status_e  status;
    res_sel_e res_sel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_e func;
    logic  empty;
    logic  full;
    logic  match;
    logic  last;
    logic  last2;
  } dp_sts_t;

endpackage

>>> sv/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bdq_dp.sv
// Datapath of the deque: entry store, head and fill registers, scan index and result register.
module bdq_dp #(
  parameter int unsigned DEPTH      = bdq_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = bdq_pkg::DataWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bdq_pkg::in_item_t  in_item_i,
  input  bdq_pkg::dp_cmd_t   cmd_i,
  output bdq_pkg::dp_sts_t   sts_o,
  output bdq_pkg::out_item_t out_item_o
);
  import bdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [AW-1:0]         head_q, head_d, head_dec_val;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         idx_q;
  logic [FuncW-1:0]      func_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [DATA_WIDTH-1:0] held_q;
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] res_val;
  logic [AW-1:0]         raddr, waddr;
  logic [SW-1:0]         idx_ext;
  out_item_t             out_q;

  // Maps an offset from the front entry to a store address.
  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] head, input logic [SW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(head) + off;
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign idx_ext      = SW'(idx_q);
  assign head_dec_val = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

  // Read address selection.
  always_comb begin
    case (cmd_i.rd_sel)
      RD_BACK:  raddr = wrap(head_q, SW'(cnt_q) - SW'(1));
      RD_FRONT: raddr = head_q;
      RD_IDX:   raddr = wrap(head_q, idx_ext);
      RD_NEXT:  raddr = wrap(head_q, idx_ext + SW'(1));
      RD_NEXT2: raddr = wrap(head_q, idx_ext + SW'(2));
      default:  raddr = head_q;
    endcase
  end

  // Write address and data selection.
  always_comb begin
    wdata = value_q;
    case (cmd_i.wr_sel)
      WR_BACK:  waddr = wrap(head_q, SW'(cnt_q));
      WR_FRONT: waddr = head_dec_val;
      WR_SHIFT: begin
        waddr = wrap(head_q, idx_ext);
        wdata = rdata;
      end
      default:  waddr = head_q;
    endcase
  end

  bdq_ram #(
    .Width(DATA_WIDTH),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Head and fill count updates.
  always_comb begin
    head_d = head_q;
    if (cmd_i.head_dec) begin
      head_d = head_dec_val;
    end else if (cmd_i.head_inc) begin
      head_d = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
    end
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  // Request capture and scan index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= in_item_i.func;
      value_q <= DATA_WIDTH'(in_item_i.item_value);
      idx_q   <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + AW'(1);
    end
    if (cmd_i.hold_rdata) begin
      held_q <= rdata;
    end
  end

  // Returned value selection.
  always_comb begin
    case (cmd_i.res_sel)
      RES_RDATA: res_val = rdata;
      RES_HELD:  res_val = held_q;
      default:   res_val = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.status      <= cmd_i.status;
      out_q.out_value   <= ValueW'(res_val);
      out_q.entry_count <= CountW'(cnt_d);
    end
  end

  assign out_item_o = out_q;

  // Status toward the controller.
  assign sts_o.func  = func_e'(func_q);
  assign sts_o.empty = (cnt_q == '0);
  assign sts_o.full  = (cnt_q == CW'(DEPTH));
  assign sts_o.match = (rdata == value_q);
  assign sts_o.last  = ((idx_ext + SW'(1)) == SW'(cnt_q));
  assign sts_o.last2 = ((idx_ext + SW'(2)) >= SW'(cnt_q));

endmodule

>>> sv/bdq_ctrl.sv
// Controller of the deque: request sequencing, handshakes and datapath commands.
module bdq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  bdq_pkg::dp_sts_t  sts_i,
  output bdq_pkg::dp_cmd_t  cmd_o
);
  import bdq_pkg::*;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free;
  dp_cmd_t cmd;

  // The output register can take a result when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    cmd.rd_sel  = RD_IDX;
    cmd.wr_sel  = WR_BACK;
    cmd.status  = STATUS_OK;
    cmd.res_sel = RES_ZERO;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.func)
          FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
            if (out_free) begin
              cmd.emit = 1'b1;
              if (sts_i.full) begin
                cmd.status = STATUS_FULL;
              end else begin
                cmd.wr_en    = 1'b1;
                cmd.cnt_inc  = 1'b1;
                cmd.wr_sel   = (sts_i.func == FUNC_PUSH_FRONT) ? WR_FRONT : WR_BACK;
                cmd.head_dec = (sts_i.func == FUNC_PUSH_FRONT);
              end
              state_d = ST_IDLE;
            end
          end
          FUNC_POP_BACK, FUNC_POP_FRONT: begin
            if (sts_i.empty) begin
              if (out_free) begin
                cmd.emit   = 1'b1;
                cmd.status = STATUS_EMPTY;
                state_d    = ST_IDLE;
              end
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = (sts_i.func == FUNC_POP_FRONT) ? RD_FRONT : RD_BACK;
              state_d    = ST_POP_WAIT;
            end
          end
          FUNC_REMOVE: begin
            if (sts_i.empty) begin
              if (out_free) begin
                cmd.emit   = 1'b1;
                cmd.status = STATUS_EMPTY;
                state_d    = ST_IDLE;
              end
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_IDX;
              state_d    = ST_SCAN;
            end
          end
          default: begin
            // Unused request codes leave the store alone.
            if (out_free) begin
              cmd.emit = 1'b1;
              state_d  = ST_IDLE;
            end
          end
        endcase
      end
      ST_POP_WAIT: begin
        if (out_free) begin
          cmd.emit     = 1'b1;
          cmd.res_sel  = RES_RDATA;
          cmd.cnt_dec  = 1'b1;
          cmd.head_inc = (sts_i.func == FUNC_POP_FRONT);
          state_d      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Compare the entry at the index while fetching the one after it.
        if (sts_i.match) begin
          cmd.hold_rdata = 1'b1;
          state_d        = ST_SHIFT_RD;
        end else if (sts_i.last) begin
          if (out_free) begin
            cmd.emit   = 1'b1;
            cmd.status = STATUS_NOT_FOUND;
            state_d    = ST_IDLE;
          end
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_NEXT;
          cmd.idx_inc = 1'b1;
        end
      end
      ST_SHIFT_RD: begin
        if (sts_i.last) begin
          if (out_free) begin
            cmd.emit    = 1'b1;
            cmd.res_sel = RES_HELD;
            cmd.cnt_dec = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
          state_d    = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        // Move the fetched entry into the gap and fetch the next one.
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_SHIFT;
        cmd.idx_inc = 1'b1;
        if (sts_i.last2) begin
          state_d = ST_SHIFT_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT2;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid tracking.
  always_comb begin
    if (cmd.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

>>> sv/bounded_deque_with_remove_core.sv
// Top level of the bounded deque with remove-by-value.
//
// A deque of up to DEPTH signed values kept in a circular RAM. Each request item
// pushes or pops at either end or removes the first entry from the front that
// equals the given value, closing the gap; each gives one result item with a
// status, the value popped or removed, and the new entry count. One request is
// worked at a time and the result sits in an output register, so the next
// request is taken while a result waits. A remove scans the entries from the
// front up to the match and then moves each entry after the match one place
// toward the front; a miss scans every entry held.
module bounded_deque_with_remove_core #(
  parameter int unsigned DEPTH      = bdq_pkg::DepthDef,
  parameter int unsigned DATA_WIDTH = bdq_pkg::DataWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bdq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bdq_pkg::out_item_t out_item_o
);
  import bdq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bdq_dp #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_item_o(out_item_o)
  );

endmodule

>>> tb/sv/bounded_deque_with_remove_core_tb.sv
// Self-checking testbench for the bounded deque with remove-by-value.
module bounded_deque_with_remove_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  // Run sizing and limits.
  localparam int unsigned RandomItems   = 1100;
  localparam int unsigned TargetPeriod  = 48;
  localparam int unsigned PhasePeriod   = 100;
  localparam int unsigned HoldOffAfter  = 400;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned StallLimit    = 4000;

  // Request codes the block leaves without effect.
  localparam logic [FuncW-1:0] FuncSpareLow  = 3'd5;
  localparam logic [FuncW-1:0] FuncSpareHigh = 3'd7;

  // Idle phases shared by the sender and the receiver.
  localparam int IdleNone     = 0;
  localparam int IdleBoth     = 1;
  localparam int IdleSender   = 2;
  localparam int IdleReceiver = 3;

  // One row of the directed stimulus; typed rows carry their own result.
  typedef struct {
    logic [FuncW-1:0]  func;
    logic [ValueW-1:0] value;
    int unsigned       reps;
    bit                has_typed;
    out_item_t         typed;
  } directed_row_t;

  localparam int NumDirected = 20;

  directed_row_t directed_rows [NumDirected] = '{
    '{FUNC_POP_BACK,   32'h0000_0000, 1, 1'b1, '{STATUS_EMPTY,     32'h0000_0000, 5'd0}},
    '{FUNC_POP_FRONT,  32'h0000_0000, 1, 1'b1, '{STATUS_EMPTY,     32'h0000_0000, 5'd0}},
    '{FUNC_REMOVE,     32'h0000_0000, 1, 1'b1, '{STATUS_EMPTY,     32'h0000_0000, 5'd0}},
    '{FuncSpareLow,    32'hFFFF_FFFF, 1, 1'b1, '{STATUS_OK,        32'h0000_0000, 5'd0}},
    '{FUNC_PUSH_BACK,  32'h7FFF_FFFF, 1, 1'b1, '{STATUS_OK,        32'h0000_0000, 5'd1}},
    '{FUNC_PUSH_FRONT, 32'h8000_0000, 1, 1'b1, '{STATUS_OK,        32'h0000_0000, 5'd2}},
    '{FUNC_PUSH_BACK,  32'h0000_0000, 1, 1'b1, '{STATUS_OK,        32'h0000_0000, 5'd3}},
    '{FUNC_PUSH_BACK,  32'hFFFF_FFFF, 1, 1'b1, '{STATUS_OK,        32'h0000_0000, 5'd4}},
    '{FUNC_REMOVE,     32'h0000_0001, 1, 1'b1, '{STATUS_NOT_FOUND, 32'h0000_0000, 5'd4}},
    '{FUNC_REMOVE,     32'h8000_0000, 1, 1'b1, '{STATUS_OK,        32'h8000_0000, 5'd3}},
    '{FUNC_REMOVE,     32'hFFFF_FFFF, 1, 1'b1, '{STATUS_OK,        32'hFFFF_FFFF, 5'd2}},
    '{FUNC_PUSH_FRONT, 32'd100,       7, 1'b0, '0},
    '{FUNC_PUSH_BACK,  32'd200,       7, 1'b0, '0},
    '{FUNC_PUSH_BACK,  32'h5555_AAAA, 1, 1'b1, '{STATUS_FULL,      32'h0000_0000, 5'd16}},
    '{FuncSpareHigh,   32'h0000_0000, 1, 1'b1, '{STATUS_OK,        32'h0000_0000, 5'd16}},
    '{FUNC_PUSH_FRONT, 32'hAAAA_5555, 1, 1'b1, '{STATUS_FULL,      32'h0000_0000, 5'd16}},
    '{FUNC_REMOVE,     32'h0000_0000, 1, 1'b0, '0},
    '{FUNC_REMOVE,     32'd206,       1, 1'b0, '0},
    '{FUNC_POP_BACK,   32'h0000_0000, 1, 1'b0, '0},
    '{FUNC_POP_FRONT,  32'h0000_0000, 1, 1'b0, '0}
  };

  // Block interface.
  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Shadow copy of the deque used to predict every result.
  logic [DataWidthDef-1:0] shadow_entries [DepthDef];
  int unsigned             shadow_head = 0;
  int unsigned             shadow_fill = 0;

  // Results waiting to come out of the block, oldest first.
  out_item_t awaited_results [$];

  int          error_count   = 0;
  int          idle_phase    = IdleBoth;
  int unsigned results_seen  = 0;
  int unsigned stall_left    = 0;
  bit          hold_off_done = 1'b0;
  int unsigned idle_cycles   = 0;
  out_item_t   want;

  bounded_deque_with_remove_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Position in the store of the entry at a given distance from the front.
  function automatic int unsigned slot_of(int unsigned offset);
    return (shadow_head + offset) % DepthDef;
  endfunction

  // Apply one request to the shadow deque and return the result it gives.
  function automatic out_item_t apply_to_shadow_deque(in_item_t req);
    out_item_t               res;
    logic [DataWidthDef-1:0] key;
    int unsigned             pos;
    res = '0;
    key = DataWidthDef'(req.item_value);
    case (req.func)
      FUNC_PUSH_BACK: begin
        if (shadow_fill == DepthDef) begin
          res.status = STATUS_FULL;
        end else begin
          shadow_entries[slot_of(shadow_fill)] = key;
          shadow_fill++;
        end
      end
      FUNC_PUSH_FRONT: begin
        if (shadow_fill == DepthDef) begin
          res.status = STATUS_FULL;
        end else begin
          shadow_head = (shadow_head + DepthDef - 1) % DepthDef;
          shadow_entries[shadow_head] = key;
          shadow_fill++;
        end
      end
      FUNC_POP_BACK: begin
        if (shadow_fill == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.out_value = ValueW'(shadow_entries[slot_of(shadow_fill - 1)]);
          shadow_fill--;
        end
      end
      FUNC_POP_FRONT: begin
        if (shadow_fill == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          res.out_value = ValueW'(shadow_entries[shadow_head]);
          shadow_head = slot_of(1);
          shadow_fill--;
        end
      end
      FUNC_REMOVE: begin
        if (shadow_fill == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          // Find the first match from the front, then close the gap behind it.
          pos = 0;
          while (pos < shadow_fill && shadow_entries[slot_of(pos)] !== key) pos++;
          if (pos == shadow_fill) begin
            res.status = STATUS_NOT_FOUND;
          end else begin
            res.out_value = ValueW'(shadow_entries[slot_of(pos)]);
            for (; pos + 1 < shadow_fill; pos++) begin
              shadow_entries[slot_of(pos)] = shadow_entries[slot_of(pos + 1)];
            end
            shadow_fill--;
          end
        end
      end
      default: begin
      end
    endcase
    res.entry_count = CountW'(shadow_fill);
    return res;
  endfunction

  // Idle length: mostly none, sometimes short, now and then long.
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!enabled || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Values to push: small ones for duplicates, the extremes, or anything.
  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0, 1: return ValueW'($urandom_range(0, 6)) - ValueW'(3);
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return ValueW'($urandom());
    endcase
  endfunction

  // Offer one request item, wait for it to be taken, and record its result.
  task automatic send_request(in_item_t req, bit has_typed, out_item_t typed);
    int unsigned gap;
    out_item_t   predicted;
    gap = pick_gap(idle_phase == IdleBoth || idle_phase == IdleSender);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i  <= req;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = apply_to_shadow_deque(req);
    awaited_results.push_back(has_typed ? typed : predicted);
  endtask

  // Result side: check each accepted result item and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result item with no expectation waiting: status %0d out_value %0d count %0d",
                 out_item_o.status, out_item_o.out_value, out_item_o.entry_count);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_item_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item_o.status);
            error_count++;
          end
          if (out_item_o.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, out_item_o.out_value);
            error_count++;
          end
          if (out_item_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   want.entry_count, out_item_o.entry_count);
            error_count++;
          end
        end
      end
      // Random stalls, and one long hold-off that lets the block back up and stall its input.
      if (stall_left == 0) begin
        stall_left = pick_gap(idle_phase == IdleBoth || idle_phase == IdleReceiver);
      end
      if (!hold_off_done && results_seen >= HoldOffAfter) begin
        stall_left    = HoldOffCycles;
        hold_off_done = 1'b1;
      end
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Stimulus: directed rows first, then random request traffic.
  initial begin
    in_item_t    req;
    int unsigned counted;
    int unsigned item_no;
    int unsigned fill_target;
    bit          grow;
    counted     = 0;
    item_no     = 0;
    fill_target = DepthDef / 2;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int row = 0; row < NumDirected; row++) begin
      for (int unsigned k = 0; k < directed_rows[row].reps; k++) begin
        req.func       = directed_rows[row].func;
        req.item_value = directed_rows[row].value + ValueW'(k);
        send_request(req, directed_rows[row].has_typed, directed_rows[row].typed);
      end
    end

    // Random traffic that drifts the fill level toward a moving target.
    while (counted < RandomItems) begin
      if (item_no % PhasePeriod == 0) idle_phase = $urandom_range(IdleNone, IdleReceiver);
      if (item_no % TargetPeriod == 0) begin
        case ($urandom_range(0, 5))
          0: fill_target = 0;
          1: fill_target = DepthDef;
          default: fill_target = $urandom_range(1, DepthDef - 1);
        endcase
      end
      item_no++;
      case ($urandom_range(0, 99)) inside
        [0:2]: begin
          req.func       = FuncSpareLow + FuncW'($urandom_range(0, 2));
          req.item_value = ValueW'($urandom());
        end
        [3:17]: begin
          req.func = FUNC_REMOVE;
          if (shadow_fill != 0 && $urandom_range(0, 3) != 0) begin
            req.item_value = shadow_entries[slot_of($urandom_range(0, shadow_fill - 1))];
          end else begin
            req.item_value = pick_value();
          end
        end
        default: begin
          if (shadow_fill < fill_target) grow = ($urandom_range(0, 9) < 8);
          else if (shadow_fill > fill_target) grow = ($urandom_range(0, 9) < 2);
          else grow = $urandom_range(0, 1);
          if (grow) req.func = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
          else req.func = $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
          req.item_value = pick_value();
        end
      endcase
      if (req.func < FuncSpareLow) counted++;
      send_request(req, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Let every awaited result arrive, then watch a little longer.
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bdq_pkg.sv
sv/bdq_ram.sv
sv/bdq_dp.sv
sv/bdq_ctrl.sv
sv/bounded_deque_with_remove_core.sv
tb/sv/bounded_deque_with_remove_core_tb.sv
